### rtl/chse_pkg.sv
// ============================================================================
// chse_pkg
// types and constants shared by the cubic hermite segment evaluator
// ============================================================================
package chse_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int T_W          = FRAC_BITS + 1;
    localparam int RATIO_W      = 18;
    localparam int CTRL_W       = 32;
    localparam int VALUE_W      = 40;
    localparam int W_W          = 20;
    localparam int PROD_W       = CTRL_W + W_W;
    localparam int ACC_W        = PROD_W + 2;
    localparam int IDX_OUT_W    = 6;
    localparam int CNT_IN_W     = 7;
    localparam int RESULT_LIMIT = 64;
    localparam int DIV_STEPS    = T_W;
    localparam int STEP_W       = $clog2(DIV_STEPS);

    localparam logic [1:0] ACT_POS   = 2'd0;
    localparam logic [1:0] ACT_VEL   = 2'd1;
    localparam logic [1:0] ACT_ACC   = 2'd2;
    localparam logic [1:0] ACT_BATCH = 2'd3;

    typedef enum logic [1:0] {
        KIND_POS,
        KIND_VEL,
        KIND_ACC
    } kind_t;

    typedef enum logic [1:0] {
        MUL_T_T,
        MUL_T2_T,
        MUL_W_C
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_SQUARE,
        ST_CUBE,
        ST_WEIGHT,
        ST_MAC,
        ST_ACC,
        ST_ROUND,
        ST_ERROR
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       decode;
        logic       div_step;
        logic       mul_en;
        mul_sel_t   mul_sel;
        logic [1:0] mac_idx;
        logic       t2_load;
        logic       w_load;
        logic       acc_add;
        logic       out_load;
        logic       out_err;
        logic       advance;
    } cmd_t;

    typedef struct packed {
        logic is_batch;
        logic count_zero;
        logic ratio_bad;
        logic batch_last;
    } status_t;

endpackage

### rtl/chse_in_if.sv
// ============================================================================
// chse_in_if
// input channel: one axis of a hermite segment plus action and parameter
// ============================================================================
interface chse_in_if;

    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            action;
    logic [1:0]                            axis;
    logic signed [chse_pkg::CTRL_W-1:0]    tan_a;
    logic signed [chse_pkg::CTRL_W-1:0]    pos_a;
    logic signed [chse_pkg::CTRL_W-1:0]    pos_b;
    logic signed [chse_pkg::CTRL_W-1:0]    tan_b;
    logic signed [chse_pkg::RATIO_W-1:0]   ratio;
    logic [chse_pkg::CNT_IN_W-1:0]         sample_count;

    modport source (
        output valid, action, axis, tan_a, pos_a, pos_b,
               tan_b, ratio, sample_count,
        input  ready
    );

    modport sink (
        input  valid, action, axis, tan_a, pos_a, pos_b,
               tan_b, ratio, sample_count,
        output ready
    );

endinterface

### rtl/chse_out_if.sv
// ============================================================================
// chse_out_if
// result channel: value, status, axis tag, sample index and last flag
// ============================================================================
interface chse_out_if;

    logic                                  valid;
    logic                                  ready;
    logic signed [chse_pkg::VALUE_W-1:0]   value;
    logic                                  status;
    logic [1:0]                            axis_out;
    logic [chse_pkg::IDX_OUT_W-1:0]        sample_index;
    logic                                  last;

    modport source (
        output valid, value, status, axis_out, sample_index, last,
        input  ready
    );

    modport sink (
        input  valid, value, status, axis_out, sample_index, last,
        output ready
    );

endinterface

### rtl/chse_ctrl.sv
// ============================================================================
// chse_ctrl
// sequencer: steps the shared multiplier, divider and output register
// ============================================================================
module chse_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  chse_pkg::status_t stat,
    output chse_pkg::cmd_t    cmd
);

    chse_pkg::state_t             state_reg;
    chse_pkg::state_t             state_next;
    logic [chse_pkg::STEP_W-1:0]  step_reg;
    logic [chse_pkg::STEP_W-1:0]  step_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= chse_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            chse_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = chse_pkg::ST_DECODE;
                end
            end
            chse_pkg::ST_DECODE:
            begin
                if (stat.is_batch)
                begin
                    state_next = stat.count_zero ? chse_pkg::ST_IDLE : chse_pkg::ST_DIV;
                end
                else
                begin
                    state_next = stat.ratio_bad ? chse_pkg::ST_ERROR : chse_pkg::ST_SQUARE;
                end
            end
            chse_pkg::ST_DIV:
            begin
                if (step_reg == chse_pkg::STEP_W'(chse_pkg::DIV_STEPS - 1))
                begin
                    state_next = chse_pkg::ST_SQUARE;
                end
            end
            chse_pkg::ST_SQUARE: state_next = chse_pkg::ST_CUBE;
            chse_pkg::ST_CUBE:   state_next = chse_pkg::ST_WEIGHT;
            chse_pkg::ST_WEIGHT: state_next = chse_pkg::ST_MAC;
            chse_pkg::ST_MAC:
            begin
                if (step_reg == chse_pkg::STEP_W'(3))
                begin
                    state_next = chse_pkg::ST_ACC;
                end
            end
            chse_pkg::ST_ACC:    state_next = chse_pkg::ST_ROUND;
            chse_pkg::ST_ROUND:
            begin
                if (out_free)
                begin
                    state_next = (stat.is_batch && !stat.batch_last) ?
                                 chse_pkg::ST_SQUARE : chse_pkg::ST_IDLE;
                end
            end
            chse_pkg::ST_ERROR:
            begin
                if (out_free)
                begin
                    state_next = chse_pkg::ST_IDLE;
                end
            end
            default: state_next = chse_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd            = '0;
        cmd.mul_sel    = chse_pkg::MUL_T_T;
        in_ready       = 1'b0;
        step_next      = '0;
        case (state_reg)
            chse_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            chse_pkg::ST_DECODE:
            begin
                cmd.decode = 1'b1;
            end
            chse_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
            end
            chse_pkg::ST_SQUARE:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = chse_pkg::MUL_T_T;
            end
            chse_pkg::ST_CUBE:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = chse_pkg::MUL_T2_T;
                cmd.t2_load = 1'b1;
            end
            chse_pkg::ST_WEIGHT:
            begin
                cmd.w_load = 1'b1;
            end
            chse_pkg::ST_MAC:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = chse_pkg::MUL_W_C;
                cmd.mac_idx = step_reg[1:0];
                cmd.acc_add = (step_reg != '0);
                step_next   = step_reg + 1'b1;
            end
            chse_pkg::ST_ACC:
            begin
                cmd.acc_add = 1'b1;
            end
            chse_pkg::ST_ROUND:
            begin
                cmd.out_load = out_free;
                cmd.advance  = out_free && stat.is_batch && !stat.batch_last;
            end
            chse_pkg::ST_ERROR:
            begin
                cmd.out_load = out_free;
                cmd.out_err  = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

### rtl/chse_dpath.sv
// ============================================================================
// chse_dpath
// datapath: shared 32x20 multiplier, accumulator, ratio divider, result register
// ============================================================================
module chse_dpath #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic                                 clk,
    input  logic [1:0]                           action,
    input  logic [1:0]                           axis,
    input  logic signed [chse_pkg::CTRL_W-1:0]   tan_a,
    input  logic signed [chse_pkg::CTRL_W-1:0]   pos_a,
    input  logic signed [chse_pkg::CTRL_W-1:0]   pos_b,
    input  logic signed [chse_pkg::CTRL_W-1:0]   tan_b,
    input  logic signed [chse_pkg::RATIO_W-1:0]  ratio,
    input  logic [chse_pkg::CNT_IN_W-1:0]        sample_count,
    input  chse_pkg::cmd_t                       cmd,
    output chse_pkg::status_t                    stat,
    output logic signed [chse_pkg::VALUE_W-1:0]  value,
    output logic                                 status,
    output logic [1:0]                           axis_out,
    output logic [chse_pkg::IDX_OUT_W-1:0]       sample_index,
    output logic                                 last
);

    localparam int CAP   = (MAX_SAMPLES < chse_pkg::RESULT_LIMIT) ?
                           MAX_SAMPLES : chse_pkg::RESULT_LIMIT;
    localparam int CNT_W = $clog2(CAP + 1);
    localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int T_W   = chse_pkg::T_W;
    localparam int W_W   = chse_pkg::W_W;
    localparam int WX_W  = W_W + 2;
    localparam int ACC_W = chse_pkg::ACC_W;
    localparam int PROD_W = chse_pkg::PROD_W;
    localparam int CTRL_W = chse_pkg::CTRL_W;
    localparam int VALUE_W = chse_pkg::VALUE_W;
    localparam int FB    = chse_pkg::FRAC_BITS;

    localparam logic [T_W-1:0]          T_ONE  = T_W'(1) << FB;
    localparam logic signed [WX_W-1:0]  W_ONE  = WX_W'(1) << FB;
    localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) << (FB - 1);
    localparam logic signed [ACC_W-1:0] VAL_MAX =
        {{(ACC_W - VALUE_W + 1){1'b0}}, {(VALUE_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] VAL_MIN =
        {{(ACC_W - VALUE_W + 1){1'b1}}, {(VALUE_W - 1){1'b0}}};
    localparam logic signed [chse_pkg::RATIO_W-1:0] RATIO_ONE =
        chse_pkg::RATIO_W'(1) << FB;

    // captured item
    chse_pkg::kind_t                       kind_reg;
    logic                                  batch_reg;
    logic [1:0]                            axis_reg;
    logic signed [CTRL_W-1:0]              ctrl_reg [4];
    logic signed [chse_pkg::RATIO_W-1:0]   ratio_reg;
    logic [CNT_W-1:0]                      count_reg;

    // curve parameter, batch stepping and divider
    logic [T_W-1:0]                        t_reg;
    logic [T_W-1:0]                        t2_reg;
    logic [CNT_W-1:0]                      frac_reg;
    logic [IDX_W-1:0]                      idx_reg;
    logic [T_W-1:0]                        quot_reg;
    logic [CNT_W-1:0]                      rem_reg;
    logic [T_W-1:0]                        num_reg;

    // arithmetic
    logic signed [W_W-1:0]                 w_reg [4];
    logic signed [PROD_W-1:0]              prod_reg;
    logic signed [ACC_W-1:0]               acc_reg;

    // result register
    logic signed [VALUE_W-1:0]             value_reg;
    logic                                  status_reg;
    logic [1:0]                            axis_out_reg;
    logic [chse_pkg::IDX_OUT_W-1:0]        index_reg;
    logic                                  last_reg;

    logic [CNT_W-1:0]                      count_sat;
    logic [T_W-1:0]                        t_hi;
    logic signed [CTRL_W-1:0]              mul_a;
    logic signed [W_W-1:0]                 mul_b;
    logic signed [WX_W-1:0]                ts;
    logic signed [WX_W-1:0]                t2s;
    logic signed [WX_W-1:0]                t3s;
    logic signed [WX_W-1:0]                w_calc [4];
    logic [CNT_W:0]                        rem_sh;
    logic                                  div_ge;
    logic [CNT_W:0]                        frac_sum;
    logic                                  frac_wrap;
    logic signed [ACC_W-1:0]               rounded;
    logic signed [VALUE_W-1:0]             sat_value;
    logic                                  batch_last;

    assign count_sat = (sample_count > chse_pkg::CNT_IN_W'(CAP)) ?
                       CNT_W'(CAP) : CNT_W'(sample_count);
    assign t_hi      = prod_reg[FB +: T_W];

    // shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            chse_pkg::MUL_T_T:
            begin
                mul_a = $signed(CTRL_W'(t_reg));
                mul_b = $signed(W_W'(t_reg));
            end
            chse_pkg::MUL_T2_T:
            begin
                mul_a = $signed(CTRL_W'(t_hi));
                mul_b = $signed(W_W'(t_reg));
            end
            chse_pkg::MUL_W_C:
            begin
                mul_a = ctrl_reg[cmd.mac_idx];
                mul_b = w_reg[cmd.mac_idx];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // hermite basis weights
    assign ts  = $signed(WX_W'(t_reg));
    assign t2s = $signed(WX_W'(t2_reg));
    assign t3s = $signed(WX_W'(t_hi));

    always_comb
    begin
        case (kind_reg)
            chse_pkg::KIND_POS:
            begin
                w_calc[0] = t3s - (t2s <<< 1) + ts;
                w_calc[1] = (t3s <<< 1) - (t2s <<< 1) - t2s + W_ONE;
                w_calc[2] = (t2s <<< 1) + t2s - (t3s <<< 1);
                w_calc[3] = t3s - t2s;
            end
            chse_pkg::KIND_VEL:
            begin
                w_calc[0] = (t2s <<< 1) + t2s - (ts <<< 2) + W_ONE;
                w_calc[1] = (t2s <<< 2) + (t2s <<< 1) - (ts <<< 2) - (ts <<< 1);
                w_calc[2] = (ts <<< 2) + (ts <<< 1) - (t2s <<< 2) - (t2s <<< 1);
                w_calc[3] = (t2s <<< 1) + t2s - (ts <<< 1);
            end
            chse_pkg::KIND_ACC:
            begin
                w_calc[0] = (ts <<< 2) + (ts <<< 1) - (W_ONE <<< 2);
                w_calc[1] = (ts <<< 3) + (ts <<< 2) - (W_ONE <<< 2) - (W_ONE <<< 1);
                w_calc[2] = (W_ONE <<< 2) + (W_ONE <<< 1) - (ts <<< 3) - (ts <<< 2);
                w_calc[3] = (ts <<< 2) + (ts <<< 1) - (W_ONE <<< 1);
            end
            default:
            begin
                w_calc[0] = '0;
                w_calc[1] = '0;
                w_calc[2] = '0;
                w_calc[3] = '0;
            end
        endcase
    end

    // restoring divider step and batch ratio stepping
    assign rem_sh    = {rem_reg, num_reg[T_W-1]};
    assign div_ge    = rem_sh >= {1'b0, count_reg};
    assign frac_sum  = {1'b0, frac_reg} + {1'b0, rem_reg};
    assign frac_wrap = frac_sum >= {1'b0, count_reg};
    assign batch_last = ((CNT_W + 1)'(idx_reg) + 1'b1) == {1'b0, count_reg};

    // round to nearest, ties toward plus infinity, then saturate
    assign rounded   = (acc_reg + HALF) >>> FB;
    assign sat_value = (rounded > VAL_MAX) ? VAL_MAX[VALUE_W-1:0] :
                       (rounded < VAL_MIN) ? VAL_MIN[VALUE_W-1:0] :
                       rounded[VALUE_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            axis_reg    <= axis;
            ctrl_reg[0] <= tan_a;
            ctrl_reg[1] <= pos_a;
            ctrl_reg[2] <= pos_b;
            ctrl_reg[3] <= tan_b;
            ratio_reg   <= ratio;
            count_reg   <= count_sat;
            batch_reg   <= (action == chse_pkg::ACT_BATCH);
            case (action)
                chse_pkg::ACT_VEL: kind_reg <= chse_pkg::KIND_VEL;
                chse_pkg::ACT_ACC: kind_reg <= chse_pkg::KIND_ACC;
                default:           kind_reg <= chse_pkg::KIND_POS;
            endcase
        end

        if (cmd.decode)
        begin
            t_reg    <= batch_reg ? '0 : ratio_reg[T_W-1:0];
            frac_reg <= '0;
            idx_reg  <= '0;
            quot_reg <= '0;
            rem_reg  <= '0;
            num_reg  <= T_ONE;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= div_ge ? CNT_W'(rem_sh - {1'b0, count_reg}) : CNT_W'(rem_sh);
            quot_reg <= {quot_reg[T_W-2:0], div_ge};
            num_reg  <= num_reg << 1;
        end
        else if (cmd.advance)
        begin
            t_reg    <= t_reg + quot_reg + T_W'(frac_wrap);
            frac_reg <= frac_wrap ? CNT_W'(frac_sum - {1'b0, count_reg}) : CNT_W'(frac_sum);
            idx_reg  <= idx_reg + 1'b1;
        end

        if (cmd.mul_en)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end

        if (cmd.t2_load)
        begin
            t2_reg <= t_hi;
        end

        if (cmd.w_load)
        begin
            w_reg[0] <= w_calc[0][W_W-1:0];
            w_reg[1] <= w_calc[1][W_W-1:0];
            w_reg[2] <= w_calc[2][W_W-1:0];
            w_reg[3] <= w_calc[3][W_W-1:0];
            acc_reg  <= '0;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end

        if (cmd.out_load)
        begin
            value_reg    <= cmd.out_err ? '0 : sat_value;
            status_reg   <= cmd.out_err;
            axis_out_reg <= axis_reg;
            index_reg    <= (cmd.out_err || !batch_reg) ? '0 :
                            chse_pkg::IDX_OUT_W'(idx_reg);
            last_reg     <= (cmd.out_err || !batch_reg) ? 1'b1 : batch_last;
        end
    end

    assign stat.is_batch   = batch_reg;
    assign stat.count_zero = (count_reg == '0);
    assign stat.ratio_bad  = (ratio_reg < 0) || (ratio_reg > RATIO_ONE);
    assign stat.batch_last = batch_last;

    assign value        = value_reg;
    assign status       = status_reg;
    assign axis_out     = axis_out_reg;
    assign sample_index = index_reg;
    assign last         = last_reg;

endmodule

### rtl/cubic_hermite_segment_evaluator.sv
// ============================================================================
// cubic_hermite_segment_evaluator
// position and derivatives of one axis of a cubic hermite segment
// ============================================================================
// position or derivative: result registered after decode, square, cube, weight,
//   multiply-accumulate, accumulate and round steps, once the output register is free
// t outside 0..1: error result registered after decode when the output is free
// sample batch: ratio divide, then six shared-multiplier passes per sample
// next input taken the cycle after the last result is registered
// rst_n clears the sequencer and output valid asynchronously
module cubic_hermite_segment_evaluator #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic     clk,
    input  logic     rst_n,
    chse_in_if.sink  item,
    chse_out_if.source result
);

    chse_pkg::cmd_t    cmd;
    chse_pkg::status_t stat;

    chse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    chse_dpath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dpath (
        .clk           (clk),
        .action        (item.action),
        .axis          (item.axis),
        .tan_a         (item.tan_a),
        .pos_a         (item.pos_a),
        .pos_b         (item.pos_b),
        .tan_b         (item.tan_b),
        .ratio         (item.ratio),
        .sample_count  (item.sample_count),
        .cmd           (cmd),
        .stat          (stat),
        .value         (result.value),
        .status        (result.status),
        .axis_out      (result.axis_out),
        .sample_index  (result.sample_index),
        .last          (result.last)
    );

endmodule

### rtl/chse_checker.sv
// ============================================================================
// chse_checker
// port-level checks for the cubic hermite segment evaluator
// ============================================================================
module chse_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  item_valid,
    input logic                                  item_ready,
    input logic                                  result_valid,
    input logic                                  result_ready,
    input logic signed [chse_pkg::VALUE_W-1:0]   result_value,
    input logic                                  result_status,
    input logic [chse_pkg::IDX_OUT_W-1:0]        result_sample_index,
    input logic                                  result_last
);

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_value)
            && $stable(result_last) && $stable(result_sample_index))
        else $error("stalled result changed");

    // one item at a time
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("input taken while previous item in decode");

    // range error result is a single zero result
    a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_status |-> result_last && (result_value == '0)
            && (result_sample_index == '0))
        else $error("malformed range error result");

    // only batch results come without last, and those never flag an error
    a_mid_batch_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_last |-> !result_status)
        else $error("error status inside a batch");

endmodule

bind cubic_hermite_segment_evaluator chse_checker u_chse_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .item_valid          (item.valid),
    .item_ready          (item.ready),
    .result_valid        (result.valid),
    .result_ready        (result.ready),
    .result_value        (result.value),
    .result_status       (result.status),
    .result_sample_index (result.sample_index),
    .result_last         (result.last)
);

### sim/tb.sv
// ============================================================================
// tb
// self-checking bench for the cubic hermite segment evaluator: directed
// extremes, out-of-range ratios and sample batches, then random items under
// four sender/receiver idling mixes, all checked against an inline predictor
// ============================================================================
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                   MAX_SAMPLES = 64;
    localparam logic signed [31:0]   CTRL_MAX    = 32'sh7fff_ffff;
    localparam logic signed [31:0]   CTRL_MIN    = 32'sh8000_0000;
    localparam int                   T_ONE       = 1 << chse_pkg::FRAC_BITS;
    localparam int                   DRAIN_CYCLES = 60;

    typedef struct {
        logic [1:0]                             action;
        logic [1:0]                             axis;
        logic signed [chse_pkg::CTRL_W-1:0]     tan_a;
        logic signed [chse_pkg::CTRL_W-1:0]     pos_a;
        logic signed [chse_pkg::CTRL_W-1:0]     pos_b;
        logic signed [chse_pkg::CTRL_W-1:0]     tan_b;
        logic signed [chse_pkg::RATIO_W-1:0]    ratio;
        logic [chse_pkg::CNT_IN_W-1:0]          sample_count;
    } segment_item_t;

    typedef struct {
        logic signed [chse_pkg::VALUE_W-1:0]    value;
        logic                                   status;
        logic [1:0]                             axis;
        logic [chse_pkg::IDX_OUT_W-1:0]         sample_index;
        logic                                   last;
    } curve_sample_t;

    logic clk = 1'b0;
    logic rst_n;

    chse_in_if  seg_in();
    chse_out_if seg_out();

    cubic_hermite_segment_evaluator #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (seg_in),
        .result (seg_out)
    );

    curve_sample_t expected_samples[$];
    int            mismatch_count = 0;
    int            idle_pct       = 0;
    int            stall_pct      = 0;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // hermite value for one kind at ratio t, q24.16 saturated
    function automatic logic signed [chse_pkg::VALUE_W-1:0] hermite_value(
        input logic [1:0] kind,
        input longint     ctl[4],
        input longint     t
    );
        longint one;
        longint t2;
        longint t3;
        longint acc;
        longint hi;
        longint lo;
        longint w[4];
        one = longint'(1) << chse_pkg::FRAC_BITS;
        hi  = (longint'(1) << (chse_pkg::VALUE_W - 1)) - 1;
        lo  = -(longint'(1) << (chse_pkg::VALUE_W - 1));
        t2  = (t * t) >>> chse_pkg::FRAC_BITS;
        t3  = (t2 * t) >>> chse_pkg::FRAC_BITS;
        case (kind)
            chse_pkg::ACT_POS:
            begin
                w[0] = t3 - 2 * t2 + t;
                w[1] = 2 * t3 - 3 * t2 + one;
                w[2] = -2 * t3 + 3 * t2;
                w[3] = t3 - t2;
            end
            chse_pkg::ACT_VEL:
            begin
                w[0] = 3 * t2 - 4 * t + one;
                w[1] = 6 * t2 - 6 * t;
                w[2] = -6 * t2 + 6 * t;
                w[3] = 3 * t2 - 2 * t;
            end
            default:
            begin
                w[0] = 6 * t - 4 * one;
                w[1] = 12 * t - 6 * one;
                w[2] = -12 * t + 6 * one;
                w[3] = 6 * t - 2 * one;
            end
        endcase
        acc = 0;
        for (int i = 0; i < 4; i++)
            acc += w[i] * ctl[i];
        acc = (acc + (longint'(1) << (chse_pkg::FRAC_BITS - 1))) >>> chse_pkg::FRAC_BITS;
        if (acc > hi)
            acc = hi;
        if (acc < lo)
            acc = lo;
        return acc[chse_pkg::VALUE_W-1:0];
    endfunction

    function automatic void predict_samples(input segment_item_t it);
        longint        ctl[4];
        longint        t;
        int            count;
        curve_sample_t s;
        ctl[0] = longint'(it.tan_a);
        ctl[1] = longint'(it.pos_a);
        ctl[2] = longint'(it.pos_b);
        ctl[3] = longint'(it.tan_b);
        t      = longint'(it.ratio);
        s.axis = it.axis;
        if (it.action != chse_pkg::ACT_BATCH)
        begin
            s.sample_index = '0;
            s.last         = 1'b1;
            if (t < 0 || t > T_ONE)
            begin
                s.value  = '0;
                s.status = 1'b1;
            end
            else
            begin
                s.value  = hermite_value(it.action, ctl, t);
                s.status = 1'b0;
            end
            expected_samples.insert(expected_samples.size(), s);
            return;
        end
        count = it.sample_count;
        if (count > MAX_SAMPLES)
            count = MAX_SAMPLES;
        if (count > chse_pkg::RESULT_LIMIT)
            count = chse_pkg::RESULT_LIMIT;
        for (int i = 0; i < count; i++)
        begin
            s.value        = hermite_value(chse_pkg::ACT_POS, ctl,
                                           (longint'(i) << chse_pkg::FRAC_BITS) / count);
            s.status       = 1'b0;
            s.sample_index = chse_pkg::IDX_OUT_W'(i);
            s.last         = (i + 1 == count);
            expected_samples.insert(expected_samples.size(), s);
        end
    endfunction

    function automatic segment_item_t make_item(
        input logic [1:0]                           action,
        input logic [1:0]                           axis,
        input logic signed [chse_pkg::CTRL_W-1:0]   m1,
        input logic signed [chse_pkg::CTRL_W-1:0]   p1,
        input logic signed [chse_pkg::CTRL_W-1:0]   p2,
        input logic signed [chse_pkg::CTRL_W-1:0]   m2,
        input logic signed [chse_pkg::RATIO_W-1:0]  t,
        input logic [chse_pkg::CNT_IN_W-1:0]        count
    );
        segment_item_t it;
        it.action       = action;
        it.axis         = axis;
        it.tan_a        = m1;
        it.pos_a        = p1;
        it.pos_b        = p2;
        it.tan_b        = m2;
        it.ratio        = t;
        it.sample_count = count;
        return it;
    endfunction

    function automatic logic signed [chse_pkg::CTRL_W-1:0] rand_ctl();
        case ($urandom_range(0, 7))
            0:       return CTRL_MAX;
            1:       return CTRL_MIN;
            2, 3:    return chse_pkg::CTRL_W'($urandom_range(0, 32'h1f_ffff)) - 32'h10_0000;
            default: return chse_pkg::CTRL_W'($urandom());
        endcase
    endfunction

    function automatic logic signed [chse_pkg::RATIO_W-1:0] rand_ratio();
        case ($urandom_range(0, 9))
            0:       return chse_pkg::RATIO_W'($urandom_range(0, (1 << chse_pkg::RATIO_W) - 1));
            1:       return '0;
            2:       return chse_pkg::RATIO_W'(T_ONE);
            default: return chse_pkg::RATIO_W'($urandom_range(0, T_ONE));
        endcase
    endfunction

    function automatic logic [chse_pkg::CNT_IN_W-1:0] rand_count();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return chse_pkg::CNT_IN_W'($urandom_range(9, (1 << chse_pkg::CNT_IN_W) - 1));
            2:       return chse_pkg::CNT_IN_W'(MAX_SAMPLES);
            default: return chse_pkg::CNT_IN_W'($urandom_range(1, 8));
        endcase
    endfunction

    // called at a rising edge; returns at the edge of the transfer
    task automatic send_segment(input segment_item_t it);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            seg_in.valid <= 1'b0;
            @(posedge clk);
        end
        seg_in.valid        <= 1'b1;
        seg_in.action       <= it.action;
        seg_in.axis         <= it.axis;
        seg_in.tan_a        <= it.tan_a;
        seg_in.pos_a        <= it.pos_a;
        seg_in.pos_b        <= it.pos_b;
        seg_in.tan_b        <= it.tan_b;
        seg_in.ratio        <= it.ratio;
        seg_in.sample_count <= it.sample_count;
        @(posedge clk);
        while (!seg_in.ready)
            @(posedge clk);
        predict_samples(it);
    endtask

    task automatic check_sample();
        curve_sample_t want;
        if (expected_samples.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected result: value %0d status %0d axis %0d index %0d last %0d",
                         seg_out.value, seg_out.status, seg_out.axis_out,
                         seg_out.sample_index, seg_out.last);
            return;
        end
        want = expected_samples.pop_front();
        if (seg_out.value !== want.value || seg_out.status !== want.status ||
            seg_out.axis_out !== want.axis || seg_out.sample_index !== want.sample_index ||
            seg_out.last !== want.last)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch: exp value %0d status %0d axis %0d index %0d last %0d, %s",
                         want.value, want.status, want.axis, want.sample_index, want.last,
                         $sformatf("got value %0d status %0d axis %0d index %0d last %0d",
                                   seg_out.value, seg_out.status, seg_out.axis_out,
                                   seg_out.sample_index, seg_out.last));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && seg_out.valid && seg_out.ready)
            check_sample();
        seg_out.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic test_position_extremes();
        send_segment(make_item(chse_pkg::ACT_POS, 2'd0, CTRL_MAX, CTRL_MAX, CTRL_MAX,
                               CTRL_MAX, '0, '0));
        send_segment(make_item(chse_pkg::ACT_POS, 2'd1, CTRL_MIN, CTRL_MIN, CTRL_MIN,
                               CTRL_MIN, chse_pkg::RATIO_W'(T_ONE), '0));
        send_segment(make_item(chse_pkg::ACT_POS, 2'd2, CTRL_MAX, CTRL_MIN, CTRL_MAX,
                               CTRL_MIN, chse_pkg::RATIO_W'(T_ONE / 2), '0));
        send_segment(make_item(chse_pkg::ACT_VEL, 2'd0, CTRL_MAX, CTRL_MIN, CTRL_MAX,
                               CTRL_MIN, '0, '0));
        send_segment(make_item(chse_pkg::ACT_VEL, 2'd1, CTRL_MIN, CTRL_MAX, CTRL_MIN,
                               CTRL_MAX, chse_pkg::RATIO_W'(T_ONE), '0));
        send_segment(make_item(chse_pkg::ACT_VEL, 2'd2, 32'sh0001_0000, 32'sh0002_0000,
                               -32'sh0003_0000, 32'sh0000_8000,
                               chse_pkg::RATIO_W'(12345), 7'd99));
        send_segment(make_item(chse_pkg::ACT_ACC, 2'd0, CTRL_MAX, CTRL_MIN, CTRL_MAX,
                               CTRL_MIN, '0, '0));
        send_segment(make_item(chse_pkg::ACT_ACC, 2'd1, CTRL_MIN, CTRL_MAX, CTRL_MIN,
                               CTRL_MAX, chse_pkg::RATIO_W'(T_ONE), '0));
        send_segment(make_item(chse_pkg::ACT_ACC, 2'd2, '0, '0, '0, '0,
                               chse_pkg::RATIO_W'(T_ONE - 1), '0));
    endtask

    task automatic test_ratio_out_of_range();
        send_segment(make_item(chse_pkg::ACT_POS, 2'd0, CTRL_MAX, CTRL_MAX, CTRL_MAX,
                               CTRL_MAX, -18'sd1, '0));
        send_segment(make_item(chse_pkg::ACT_POS, 2'd1, CTRL_MIN, 32'sd5, 32'sd7, CTRL_MAX,
                               chse_pkg::RATIO_W'(T_ONE + 1), '0));
        send_segment(make_item(chse_pkg::ACT_VEL, 2'd2, 32'sd1, 32'sd2, 32'sd3, 32'sd4,
                               18'sh2_0000, '0));
        send_segment(make_item(chse_pkg::ACT_ACC, 2'd1, 32'sd1, 32'sd2, 32'sd3, 32'sd4,
                               18'sh1_ffff, 7'd127));
    endtask

    task automatic test_sample_batches();
        send_segment(make_item(chse_pkg::ACT_BATCH, 2'd0, CTRL_MAX, CTRL_MIN, CTRL_MAX,
                               CTRL_MIN, '0, 7'd0));
        send_segment(make_item(chse_pkg::ACT_BATCH, 2'd1, 32'sh0001_0000, '0,
                               32'sh0004_0000, 32'sh0001_0000, -18'sd5, 7'd1));
        send_segment(make_item(chse_pkg::ACT_BATCH, 2'd2, CTRL_MIN, CTRL_MAX, CTRL_MIN,
                               CTRL_MAX, chse_pkg::RATIO_W'(T_ONE + 9), 7'd3));
        send_segment(make_item(chse_pkg::ACT_BATCH, 2'd0, CTRL_MAX, CTRL_MAX, CTRL_MIN,
                               CTRL_MIN, '0, 7'd64));
        send_segment(make_item(chse_pkg::ACT_BATCH, 2'd1, 32'sh1234_5678, -32'sh0765_4321,
                               32'sh0abc_def0, -32'sh0000_ffff, '0, 7'd65));
        send_segment(make_item(chse_pkg::ACT_BATCH, 2'd2, CTRL_MIN, CTRL_MIN, CTRL_MAX,
                               CTRL_MAX, '0, 7'd127));
    endtask

    task automatic test_random_mix(input int sender_idle, input int receiver_stall,
                                   input int n_items);
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        repeat (n_items)
            send_segment(make_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 2)),
                                   rand_ctl(), rand_ctl(), rand_ctl(), rand_ctl(),
                                   rand_ratio(), rand_count()));
    endtask

    initial
    begin
        rst_n               = 1'b0;
        seg_in.valid        <= 1'b0;
        seg_in.action       <= chse_pkg::ACT_POS;
        seg_in.axis         <= '0;
        seg_in.tan_a        <= '0;
        seg_in.pos_a        <= '0;
        seg_in.pos_b        <= '0;
        seg_in.tan_b        <= '0;
        seg_in.ratio        <= '0;
        seg_in.sample_count <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_position_extremes();
        test_ratio_out_of_range();
        test_sample_batches();
        test_random_mix(0, 0, 112);
        test_random_mix(49, 0, 112);
        test_random_mix(0, 49, 112);
        test_random_mix(29, 29, 112);

        seg_in.valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_samples.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
